// File: src/cmap4_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmap4_pkg: shared types and constants for the format-4 glyph lookup
// Sizes, opcode and state encodings, and the token that walks the cell row.
// ----------------------------------------------------------------------------
package cmap4_pkg;

   localparam int MAX_SEGMENTS = 64;
   localparam int GLYPH_WORDS  = 1024;

   localparam int ACT_W   = 2;
   localparam int INDEX_W = 10;
   localparam int CODE_W  = 16;
   localparam int CP_W    = 21;
   localparam int CFG_W   = 7;

   localparam int SEG_W   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
   localparam int WADDR_W = (GLYPH_WORDS > 1) ? $clog2(GLYPH_WORDS) : 1;
   // half offset + segment + code distance stays below 2**(CODE_W+2)
   localparam int WIDX_W  = CODE_W + 3;

   localparam logic [CODE_W-1:0] MAX_CODE = 16'hFFFF;

   typedef enum logic [ACT_W-1:0] {
      ACT_SEGMENT = 2'd0,
      ACT_WORD    = 2'd1,
      ACT_LOOKUP  = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CALC,
      ST_READ
   } state_type;

   typedef enum logic [1:0] {
      RES_ZERO,
      RES_DIRECT,
      RES_TABLE,
      RES_BAD
   } result_type;

   typedef struct packed {
      logic              valid;
      logic              over;
      logic              found;
      logic [CODE_W-1:0] code;
      logic [SEG_W-1:0]  seg;
      logic [CODE_W-1:0] start;
      logic [CODE_W-1:0] delta;
      logic [CODE_W-1:0] rng;
   } token_type;

   typedef struct packed {
      logic              en;
      logic [SEG_W-1:0]  idx;
      logic [CODE_W-1:0] end_code;
      logic [CODE_W-1:0] start_code;
      logic [CODE_W-1:0] delta;
      logic [CODE_W-1:0] rng;
   } seg_write_type;

endpackage

// File: src/cmap4_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmap4_ifs: channel interfaces of the glyph lookup
// Request, response and register write channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cmap4_req_if;
   import cmap4_pkg::*;
   logic               valid;
   logic               ready;
   logic [ACT_W-1:0]   action;
   logic [INDEX_W-1:0] index;
   logic [CODE_W-1:0]  end_code;
   logic [CODE_W-1:0]  start_code;
   logic [CODE_W-1:0]  segment_delta;
   logic [CODE_W-1:0]  range_offset;
   logic [CODE_W-1:0]  glyph_word;
   logic [CP_W-1:0]    codepoint;

   modport source (output valid, action, index, end_code, start_code, segment_delta,
                   range_offset, glyph_word, codepoint, input ready);
   modport sink   (input valid, action, index, end_code, start_code, segment_delta,
                   range_offset, glyph_word, codepoint, output ready);
endinterface

interface cmap4_rsp_if;
   import cmap4_pkg::*;
   logic              valid;
   logic              ready;
   logic [CODE_W-1:0] glyph_id;
   logic              bad_index;

   modport source (output valid, glyph_id, bad_index, input ready);
   modport sink   (input valid, glyph_id, bad_index, output ready);
endinterface

interface cmap4_csr_if;
   import cmap4_pkg::*;
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// File: src/cmap4_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmap4_ram: generic single-port-write RAM with registered read
// One write and one read per cycle; read data holds until the next read.
// ----------------------------------------------------------------------------
module cmap4_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: src/cmap4_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmap4_cell: one segment of the scan row
// Holds one segment entry and claims the passing token on the first match.
// ----------------------------------------------------------------------------
module cmap4_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [cmap4_pkg::SEG_W-1:0]    cell_id,
   input  logic [cmap4_pkg::CNT_W-1:0]    live_count,
   input  cmap4_pkg::seg_write_type       seg_wr,
   input  cmap4_pkg::token_type           tok_i,
   output cmap4_pkg::token_type           tok_o
);
   import cmap4_pkg::*;

   logic [CODE_W-1:0] end_ff;
   logic [CODE_W-1:0] start_ff;
   logic [CODE_W-1:0] delta_ff;
   logic [CODE_W-1:0] rng_ff;
   token_type         tok_ff;
   token_type         tok_in;
   logic              active;
   logic              hit;

   assign active = (CNT_W'(cell_id) < live_count);

   always_comb begin
      hit    = tok_i.valid && !tok_i.found && !tok_i.over && active &&
               (end_ff >= tok_i.code);
      tok_in = tok_i;
      if (hit) begin
         tok_in.found = 1'b1;
         tok_in.seg   = cell_id;
         tok_in.start = start_ff;
         tok_in.delta = delta_ff;
         tok_in.rng   = rng_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (seg_wr.en && (seg_wr.idx == cell_id)) begin
         end_ff   <= seg_wr.end_code;
         start_ff <= seg_wr.start_code;
         delta_ff <= seg_wr.delta;
         rng_ff   <= seg_wr.rng;
      end
   end

   // advance the token one cell per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
   end

   assign tok_o = tok_ff;
endmodule

// File: src/cmap_format4_glyph_lookup_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cmap_format4_glyph_lookup_top: TrueType format-4 code point to glyph map
// Segment table in a row of cells, glyph word array in RAM, one lookup
// in flight at a time.
// ----------------------------------------------------------------------------
//
//  port     dir    word                                         handshake
//  -------  -----  -------------------------------------------  ---------------
//  req_if   in     action, index, segment fields, word, code    valid / ready
//  rsp_if   out    glyph_id, bad_index                          valid / ready
//  csr_if   in     segment_count                                valid / ready
//
// A segment or glyph word write is stored at its accept edge, and the next
// word is taken in the following cycle.
// A lookup's token walks the cell row one segment per cycle from its accept
// edge; the word index is then registered from the row's tail, the glyph RAM
// is read, and the result lands in the output register. The input reopens in
// the cycle after the result is loaded, so lookups never overlap.
// A full output register stalls the lookup in its last step; reset clears
// control state only, table contents stay undefined until written.
// ----------------------------------------------------------------------------
module cmap_format4_glyph_lookup_top (
   input  logic         clock,
   input  logic         reset,
   cmap4_req_if.sink    req_if,
   cmap4_rsp_if.source  rsp_if,
   cmap4_csr_if.sink    csr_if
);
   import cmap4_pkg::*;

   localparam int CMP_W = ((CNT_W > CFG_W) ? CNT_W : CFG_W) + 1;
   localparam int IDXC_W = ((INDEX_W > 17) ? INDEX_W : 17) + 1;

   // --- control and configuration ------------------------------------------
   state_type        state_ff;
   state_type        state_in;
   logic [CFG_W-1:0] nseg_ff;
   logic [CNT_W-1:0] nseg_sat;

   logic req_accept;
   logic ram_rd_en;
   logic load_rsp;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [CODE_W-1:0] rsp_gid_ff;
   logic [CODE_W-1:0] rsp_gid_in;
   logic              rsp_bad_ff;
   logic              rsp_bad_in;

   assign req_accept = req_if.valid && req_if.ready;
   assign csr_if.ready = 1'b1;

   // saturate the segment count at the row length
   assign nseg_sat = (CMP_W'(nseg_ff) > CMP_W'(MAX_SEGMENTS)) ?
                     CNT_W'(MAX_SEGMENTS) : CNT_W'(nseg_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         nseg_ff <= '0;
      end else if (csr_if.valid && csr_if.ready) begin
         nseg_ff <= csr_if.data;
      end
   end

   // --- table writes ---------------------------------------------------------
   seg_write_type seg_wr;
   logic          word_wr_en;

   always_comb begin
      seg_wr.en         = req_accept && (req_if.action == ACT_SEGMENT) &&
                          (IDXC_W'(req_if.index) < IDXC_W'(MAX_SEGMENTS));
      seg_wr.idx        = SEG_W'(req_if.index);
      seg_wr.end_code   = req_if.end_code;
      seg_wr.start_code = req_if.start_code;
      seg_wr.delta      = req_if.segment_delta;
      seg_wr.rng        = req_if.range_offset;
      word_wr_en        = req_accept && (req_if.action == ACT_WORD) &&
                          (IDXC_W'(req_if.index) < IDXC_W'(GLYPH_WORDS));
   end

   // --- scan row -------------------------------------------------------------
   token_type                head;
   token_type                chain [MAX_SEGMENTS + 1];
   logic [MAX_SEGMENTS-1:0]  tok_valid;
   token_type                tail;

   // inject a fresh token into the first cell at the lookup's accept edge
   always_comb begin
      head       = '0;
      head.valid = req_accept && (req_if.action == ACT_LOOKUP);
      head.over  = |req_if.codepoint[CP_W-1:CODE_W];
      head.code  = req_if.codepoint[CODE_W-1:0];
   end

   assign chain[0] = head;

   for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
      cmap4_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_id    (SEG_W'(g)),
         .live_count (nseg_sat),
         .seg_wr     (seg_wr),
         .tok_i      (chain[g]),
         .tok_o      (chain[g + 1])
      );
      assign tok_valid[g] = chain[g + 1].valid;
   end

   assign tail = chain[MAX_SEGMENTS];

   // --- word index -----------------------------------------------------------
   // index = offset/2 + segment - count + (code - start); negative shows in
   // the top bit since the magnitude never reaches it
   logic [CODE_W-1:0]  code_dist;
   logic [WIDX_W-1:0]  widx;
   logic               widx_bad;
   result_type         kind_in;
   result_type         kind_ff;
   logic [CODE_W-1:0]  direct_ff;
   logic [CODE_W-1:0]  delta_ff;
   logic [WADDR_W-1:0] waddr_ff;

   always_comb begin
      code_dist = tail.code - tail.start;
      widx      = WIDX_W'(tail.rng[CODE_W-1:1]) + WIDX_W'(tail.seg) +
                  WIDX_W'(code_dist) - WIDX_W'(nseg_sat);
      widx_bad  = widx[WIDX_W-1] ||
                  (widx[WIDX_W-2:0] >= (WIDX_W-1)'(GLYPH_WORDS));
      if (!tail.found || (tail.start > tail.code)) begin
         kind_in = RES_ZERO;
      end else if (tail.rng == '0) begin
         kind_in = RES_DIRECT;
      end else if (widx_bad) begin
         kind_in = RES_BAD;
      end else begin
         kind_in = RES_TABLE;
      end
   end

   // hold the resolved segment until the glyph word comes back
   always_ff @(posedge clock) begin
      if ((state_ff == ST_SCAN) && tail.valid) begin
         kind_ff   <= kind_in;
         direct_ff <= tail.code + tail.delta;
         delta_ff  <= tail.delta;
         waddr_ff  <= WADDR_W'(widx);
      end
   end

   // --- glyph word store -----------------------------------------------------
   logic [CODE_W-1:0] word_rd;

   cmap4_ram #(
      .WIDTH (CODE_W),
      .DEPTH (GLYPH_WORDS)
   ) u_words (
      .clock   (clock),
      .wr_en   (word_wr_en),
      .wr_addr (WADDR_W'(req_if.index)),
      .wr_data (req_if.glyph_word),
      .rd_en   (ram_rd_en),
      .rd_addr (waddr_ff),
      .rd_data (word_rd)
   );

   // --- sequencer --------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_if.action == ACT_LOOKUP)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (tail.valid) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            state_in = ST_READ;
         end
         ST_READ: begin
            if (load_rsp) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_if.ready = (state_ff == ST_IDLE);
      ram_rd_en    = (state_ff == ST_CALC);
      load_rsp     = (state_ff == ST_READ) && (!rsp_valid_ff || rsp_if.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // --- output register --------------------------------------------------------
   always_comb begin
      rsp_bad_in = 1'b0;
      case (kind_ff)
         RES_DIRECT: rsp_gid_in = direct_ff;
         RES_TABLE:  rsp_gid_in = (word_rd == '0) ? '0 : word_rd + delta_ff;
         RES_BAD: begin
            rsp_gid_in = '0;
            rsp_bad_in = 1'b1;
         end
         default:    rsp_gid_in = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load_rsp) begin
         rsp_gid_ff <= rsp_gid_in;
         rsp_bad_ff <= rsp_bad_in;
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.glyph_id  = rsp_gid_ff;
   assign rsp_if.bad_index = rsp_bad_ff;

   // --- checks -----------------------------------------------------------------
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $countones(tok_valid) <= 1)
      else $error("more than one token in the scan row");

   a_scan_token: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> ($countones(tok_valid) == 1))
      else $error("scan state without a token in the row");

   a_tail_in_scan: assert property (@(posedge clock) disable iff (reset)
      tail.valid |-> (state_ff == ST_SCAN))
      else $error("token left the row outside a scan");

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_READ))
      else $error("response raised without a finished lookup");

   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> (rsp_gid_ff == '0))
      else $error("bad index reported with a nonzero glyph");
endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the format-4 glyph lookup
// Loads segment tables and glyph words, sweeps the segment count through
// its extremes, and checks every lookup word against a software mirror.
// ----------------------------------------------------------------------------
module testbench;
   import cmap4_pkg::*;

   // action code outside the enum; the block drops such words
   localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

   localparam int HALF_PERIOD   = 4;
   localparam int CODE_TOP      = int'(MAX_CODE);
   localparam int LOOKUP_CYCLES = MAX_SEGMENTS + 3;
   localparam int SETTLE_CYCLES = LOOKUP_CYCLES + 16;
   localparam int LONG_HOLD     = 500;
   localparam int MIX_WORDS     = 70;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int PHASES        = 7;

   typedef struct packed {
      logic [ACT_W-1:0]   action;
      logic [INDEX_W-1:0] index;
      logic [CODE_W-1:0]  end_code;
      logic [CODE_W-1:0]  start_code;
      logic [CODE_W-1:0]  segment_delta;
      logic [CODE_W-1:0]  range_offset;
      logic [CODE_W-1:0]  glyph_word;
      logic [CP_W-1:0]    codepoint;
   } req_word_t;

   typedef struct packed {
      logic [CODE_W-1:0] glyph_id;
      logic              bad_index;
   } glyph_t;

   // Mirror of the segment table and glyph store, plus the queue of glyphs
   // still owed by the block.
   class cmap_mirror;
      bit [CODE_W-1:0] seg_end   [MAX_SEGMENTS];
      bit [CODE_W-1:0] seg_start [MAX_SEGMENTS];
      bit [CODE_W-1:0] seg_delta [MAX_SEGMENTS];
      bit [CODE_W-1:0] seg_range [MAX_SEGMENTS];
      bit [CODE_W-1:0] words     [GLYPH_WORDS];
      bit              word_set  [GLYPH_WORDS];
      int              live_segs;
      glyph_t          glyph_due [$];
      int              errors;

      function new();
         live_segs = 0;
         errors    = 0;
      endfunction

      // counts above the table size saturate
      function void set_count(logic [CFG_W-1:0] value);
         live_segs = (value > MAX_SEGMENTS) ? MAX_SEGMENTS : int'(value);
      endfunction

      // word_at returns the glyph store entry read, or -1 when none is read
      function glyph_t map_code(input logic [CP_W-1:0] cp, output int word_at);
         glyph_t g;
         int     seg;
         int     widx;
         int     i;
         g       = '0;
         word_at = -1;
         seg     = -1;
         if (cp > MAX_CODE) return g;
         for (i = 0; i < live_segs && seg < 0; i++)
            if (seg_end[i] >= cp[CODE_W-1:0]) seg = i;
         if (seg < 0 || seg_start[seg] > cp[CODE_W-1:0]) return g;
         if (seg_range[seg] == '0) begin
            g.glyph_id = cp[CODE_W-1:0] + seg_delta[seg];
            return g;
         end
         // odd byte offsets floor to the word below
         widx = int'(seg_range[seg] >> 1) + seg - live_segs
              + int'(cp) - int'(seg_start[seg]);
         if (widx < 0 || widx >= GLYPH_WORDS) begin
            g.bad_index = 1'b1;
            return g;
         end
         word_at = widx;
         if (words[widx] != '0) g.glyph_id = words[widx] + seg_delta[seg];
         return g;
      endfunction

      function void take_word(req_word_t w);
         int word_at;
         case (w.action)
            ACT_SEGMENT: begin
               if (w.index < MAX_SEGMENTS) begin
                  seg_end[w.index]   = w.end_code;
                  seg_start[w.index] = w.start_code;
                  seg_delta[w.index] = w.segment_delta;
                  seg_range[w.index] = w.range_offset;
               end
            end
            ACT_WORD: begin
               if (w.index < GLYPH_WORDS) begin
                  words[w.index]    = w.glyph_word;
                  word_set[w.index] = 1'b1;
               end
            end
            ACT_LOOKUP: glyph_due.push_back(map_code(w.codepoint, word_at));
            default: ;
         endcase
      endfunction

      function void check_glyph(logic [CODE_W-1:0] gid, logic bad);
         glyph_t e;
         if (glyph_due.size() == 0) begin
            $error("unexpected result: glyph_id %h bad_index %b", gid, bad);
            errors++;
            return;
         end
         e = glyph_due.pop_front();
         if (gid !== e.glyph_id) begin
            $error("glyph_id: expected %h, got %h", e.glyph_id, gid);
            errors++;
         end
         if (bad !== e.bad_index) begin
            $error("bad_index: expected %b, got %b", e.bad_index, bad);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   int unsigned cycles = 0;
   bit          idle_on;
   int          long_holds_asked = 0;
   cmap_mirror  board;

   cmap4_req_if req_bus ();
   cmap4_rsp_if rsp_bus ();
   cmap4_csr_if csr_bus ();

   cmap_format4_glyph_lookup_top i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   // Hard stop: a hung handshake must not run forever.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // Sample the result channel at the edge; the mirror owns the comparison.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
         board.check_glyph(rsp_bus.glyph_id, rsp_bus.bad_index);
   end

   // Result-side ready. Short random stalls while idling is on; a long hold
   // on request from the stimulus, counted here, lets the block back up.
   initial begin : result_side
      int hold;
      int holds_seen;
      hold       = 0;
      holds_seen = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_seen != long_holds_asked) begin
            holds_seen = long_holds_asked;
            hold       = LONG_HOLD;
         end
         if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            hold--;
         end else if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            hold = $urandom_range(0, 4);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Random payload in every field; callers overwrite what the action uses.
   function automatic req_word_t noise_word();
      req_word_t w;
      w.action        = ACT_NONE;
      w.index         = INDEX_W'($urandom);
      w.end_code      = CODE_W'($urandom);
      w.start_code    = CODE_W'($urandom);
      w.segment_delta = CODE_W'($urandom);
      w.range_offset  = CODE_W'($urandom);
      w.glyph_word    = CODE_W'($urandom);
      w.codepoint     = CP_W'($urandom);
      return w;
   endfunction

   // Offer one word on the request channel and hold it until taken. Entered
   // and left at a falling edge; valid stays high for back-to-back words.
   task automatic push(input req_word_t w);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_bus.action        <= w.action;
      req_bus.index         <= w.index;
      req_bus.end_code      <= w.end_code;
      req_bus.start_code    <= w.start_code;
      req_bus.segment_delta <= w.segment_delta;
      req_bus.range_offset  <= w.range_offset;
      req_bus.glyph_word    <= w.glyph_word;
      req_bus.codepoint     <= w.codepoint;
      req_bus.valid         <= 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      board.take_word(w);
      @(negedge clock);
   endtask

   task automatic put_segment(input int idx, input int last_code, input int first_code,
                              input int delta, input int rng);
      req_word_t w;
      w               = noise_word();
      w.action        = ACT_SEGMENT;
      w.index         = INDEX_W'(idx);
      w.end_code      = CODE_W'(last_code);
      w.start_code    = CODE_W'(first_code);
      w.segment_delta = CODE_W'(delta);
      w.range_offset  = CODE_W'(rng);
      push(w);
   endtask

   task automatic put_word(input int idx, input int value);
      req_word_t w;
      w            = noise_word();
      w.action     = ACT_WORD;
      w.index      = INDEX_W'(idx);
      w.glyph_word = CODE_W'(value);
      push(w);
   endtask

   // Look up a code point. A glyph store entry that was never written is
   // loaded first, so the block never reads an undefined word.
   task automatic look_up(input int cp);
      req_word_t w;
      int        word_at;
      void'(board.map_code(CP_W'(cp), word_at));
      if (word_at >= 0 && !board.word_set[word_at])
         put_word(word_at, ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, CODE_TOP));
      w           = noise_word();
      w.action    = ACT_LOOKUP;
      w.codepoint = CP_W'(cp);
      push(w);
   endtask

   // Drop valid, wait for every owed glyph, then let any write finish.
   task automatic settle();
      req_bus.valid <= 1'b0;
      do @(negedge clock); while (board.glyph_due.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_count(input int value);
      csr_bus.data  <= CFG_W'(value);
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      board.set_count(CFG_W'(value));
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Write a well-formed table of n segments: ascending, mostly gapped,
   // mixing delta segments, table segments that land inside the glyph store,
   // and a few with stray offsets. The last one usually ends at 0xFFFF.
   task automatic build_table(input int n);
      int next_code, first, last, rng, span, base, kind, s;
      next_code = $urandom_range(0, 200);
      for (s = 0; s < n; s++) begin
         first = next_code + $urandom_range(0, 20);
         if (first > CODE_TOP) first = CODE_TOP;
         kind = $urandom_range(0, 9);
         if (kind < 5) begin
            span = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2000) : $urandom_range(0, 40);
            rng  = 0;
         end else if (kind < 9) begin
            // half offset + s - n cancels to base, the first word read
            span = $urandom_range(0, 30);
            base = $urandom_range(0, GLYPH_WORDS - 1 - span);
            rng  = 2 * (n - s + base) + $urandom_range(0, 1);
         end else begin
            span = $urandom_range(0, 40);
            rng  = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4)
                                                : $urandom_range(1, CODE_TOP);
         end
         last = first + span;
         if (last > CODE_TOP) last = CODE_TOP;
         if (s == n - 1 && $urandom_range(0, 3) != 0) last = CODE_TOP;
         put_segment(s, last, first, $urandom_range(0, CODE_TOP), rng);
         next_code = last + 1;
      end
   endtask

   // Mostly lookups aimed into live segments and their edges; the rest are
   // word loads, segment writes that miss the live segments, dead action codes and wild codes.
   task automatic run_mix(input int count);
      int k, pick, s, cp, idx;
      for (k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         s    = (board.live_segs > 0) ? $urandom_range(0, board.live_segs - 1) : 0;
         if (pick < 60 && board.live_segs > 0) begin
            look_up($urandom_range(board.seg_start[s], board.seg_end[s]));
         end else if (pick < 70 && board.live_segs > 0) begin
            case ($urandom_range(0, 3))
               0:       cp = int'(board.seg_start[s]);
               1:       cp = int'(board.seg_end[s]);
               2:       cp = int'(board.seg_start[s]) - 1;
               default: cp = int'(board.seg_end[s]) + 1;
            endcase
            if (cp < 0) cp = 0;
            look_up(cp);
         end else if (pick < 75) begin
            look_up($urandom_range(0, CODE_TOP));
         end else if (pick < 78) begin
            look_up($urandom_range(0, 2**CP_W - 1));
         end else if (pick < 88) begin
            put_word($urandom_range(0, GLYPH_WORDS - 1),
                     ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, CODE_TOP));
         end else if (pick < 93) begin
            // keep live segments intact: move such writes past the table
            idx = $urandom_range(0, 2**INDEX_W - 1);
            if (idx < board.live_segs) idx += MAX_SEGMENTS;
            put_segment(idx, $urandom_range(0, CODE_TOP), $urandom_range(0, CODE_TOP),
                        $urandom_range(0, CODE_TOP), $urandom_range(0, CODE_TOP));
         end else if (pick < 96) begin
            push(noise_word());
         end else begin
            look_up(pick[0] ? CODE_TOP : CODE_TOP + 1);
         end
      end
   endtask

   initial begin : stimulus
      int p, c, n;
      int phase_counts[PHASES];
      board   = new();
      idle_on = 1'b1;

      // every input known from time zero
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.action        = ACT_SEGMENT;
      req_bus.index         = '0;
      req_bus.end_code      = '0;
      req_bus.start_code    = '0;
      req_bus.segment_delta = '0;
      req_bus.range_offset  = '0;
      req_bus.glyph_word    = '0;
      req_bus.codepoint     = '0;
      csr_bus.valid         = 1'b0;
      csr_bus.data          = '0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ---- directed ----
      // count is zero out of reset: any code maps to glyph zero
      look_up('h41);

      // seg 0: delta map with a wrapping delta
      put_segment(0, 'h41, 'h20, 'hFFE3, 0);
      // seg 1: odd offset floors, word index = code - 0x80
      put_segment(1, 'h100, 'h80, 'h5, 7);
      // seg 2: offset too small, index goes negative
      put_segment(2, 'h200, 'h180, 0, 2);
      // seg 3: offset far past the end of the glyph store
      put_segment(3, 'hFFF0, 'hF000, 'h1000, 'hFFFE);
      // unused slot at the top, all fields at their maximum
      put_segment(MAX_SEGMENTS - 1, CODE_TOP, CODE_TOP, CODE_TOP, CODE_TOP);
      // segment number past the table: dropped
      put_segment(2**INDEX_W - 1, 'h1234, 'h1000, 'h1, 'h2);
      put_word(0, 'h1234);
      put_word(1, 0);
      put_word(GLYPH_WORDS - 1, CODE_TOP);
      push(noise_word());
      settle();
      write_count(4);

      look_up('h20);        // delta map
      look_up('h41);        // delta wraps modulo 65536
      look_up(0);           // below the first start
      look_up('h80);        // table word plus delta
      look_up('h81);        // zero word gives glyph zero
      look_up('h150);       // gap: segment found but start above code
      look_up('h180);       // negative word index
      look_up('hF000);      // word index past the store
      look_up('hFFF5);      // past every end: no segment
      look_up(CODE_TOP + 1);
      look_up(2**CP_W - 1);
      settle();

      // ---- random phases, one segment count each ----
      phase_counts = '{1, 64, 127, 0, 0, 64, 9};
      phase_counts[4] = $urandom_range(2, MAX_SEGMENTS - 1);
      for (p = 0; p < PHASES; p++) begin
         c = phase_counts[p];
         n = (c > MAX_SEGMENTS) ? MAX_SEGMENTS : c;
         // the closing phase runs with no idling on either side
         if (p == PHASES - 1) idle_on = 1'b0;
         build_table(n);
         settle();
         write_count(c);
         if (p == 1) begin
            // hold results back while lookups keep coming
            long_holds_asked++;
            run_mix(MIX_WORDS);
         end else if (p == 4) begin
            // pause the sender until every glyph is back, then resume
            run_mix(MIX_WORDS / 2);
            settle();
            run_mix(MIX_WORDS - MIX_WORDS / 2);
         end else begin
            run_mix(MIX_WORDS);
         end
      end
      settle();

      if (board.errors == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule

// File: cmap_format4_glyph_lookup_top.f
src/cmap4_pkg.sv
src/cmap4_ifs.sv
src/cmap4_ram.sv
src/cmap4_cell.sv
src/cmap_format4_glyph_lookup_top.sv
tb/sv/testbench.sv
